// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication check, disabled in reset.
`define CHK_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("check failed");
`endif

// ===== sv/m2i_pkg.sv =====
// Shared types and constants for the 2x2 inverse core.
`timescale 1ns / 1ps
package m2i_pkg;
  localparam int InWidth  = 16;
  localparam int InFrac   = 8;
  localparam int OutFrac  = 16;
  localparam int Shift    = InFrac + OutFrac;
  localparam int NumBits  = InWidth + Shift;          // quotient bits produced
  localparam int DetWidth = 2 * InWidth + 1;          // full determinant
  localparam int DmagWidth = 2 * InWidth;             // |det| fits here
  localparam int MagWidth = InWidth;                  // |entry| fits here
  localparam int RemWidth = DmagWidth + 1;
  localparam int QWidth   = NumBits;
  localparam int CntWidth = 6;

  typedef logic signed [InWidth-1:0] entry_t;
  typedef logic [DmagWidth-1:0] dmag_t;
  typedef logic [MagWidth-1:0] mag_t;
  typedef logic [RemWidth-1:0] rem_t;
  typedef logic [QWidth-1:0] quot_t;

  // One matrix in flight through the divider chain.
  typedef struct packed {
    logic              valid;
    logic [32:0]       det;
    logic              singular;
    dmag_t             dmag;
    logic              dneg;
    logic [3:0]        nneg;
    mag_t  [3:0]       num;
    rem_t  [3:0]       rem;
    quot_t [3:0]       q;
  } stage_t;
endpackage

// ===== sv/m2i_if.sv =====
// Valid/ready channel interfaces for the inverse core.
`timescale 1ns / 1ps
interface m2i_in_if;
  import m2i_pkg::*;
  logic   valid;
  logic   ready;
  entry_t entry_a;
  entry_t entry_b;
  entry_t entry_c;
  entry_t entry_d;
  modport source (output valid, entry_a, entry_b, entry_c, entry_d, input ready);
  modport sink (input valid, entry_a, entry_b, entry_c, entry_d, output ready);
endinterface

interface m2i_out_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] det_value;
  logic signed [31:0] inv_a;
  logic signed [31:0] inv_b;
  logic signed [31:0] inv_c;
  logic signed [31:0] inv_d;
  logic               singular;
  logic               clipped;
  modport source (output valid, det_value, inv_a, inv_b, inv_c, inv_d, singular, clipped,
                  input ready);
  modport sink (input valid, det_value, inv_a, inv_b, inv_c, inv_d, singular, clipped,
                output ready);
endinterface

// ===== sv/m2i_div_cell.sv =====
// One restoring-division step for all four numerators, registered.
`timescale 1ns / 1ps
module m2i_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [m2i_pkg::CntWidth-1:0] step,
  input  m2i_pkg::stage_t din,
  output m2i_pkg::stage_t dout
);
  import m2i_pkg::*;
  stage_t nxt;
  rem_t   sh;
  logic   bit_in;
  int     src;

  always_comb begin
    nxt = din;
    for (int k = 0; k < 4; k++) begin
      src = NumBits - 1 - int'(step) - Shift;
      bit_in = (src >= 0) ? din.num[k][src[$clog2(MagWidth)-1:0]] : 1'b0;
      sh = {din.rem[k][RemWidth-2:0], bit_in};
      if (sh >= {1'b0, din.dmag}) begin
        nxt.rem[k] = sh - {1'b0, din.dmag};
        nxt.q[k] = {din.q[k][QWidth-2:0], 1'b1};
      end else begin
        nxt.rem[k] = sh;
        nxt.q[k] = {din.q[k][QWidth-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.det <= nxt.det;        dout.singular <= nxt.singular;
      dout.dmag <= nxt.dmag;      dout.dneg <= nxt.dneg;
      dout.nneg <= nxt.nneg;      dout.num <= nxt.num;
      dout.rem <= nxt.rem;        dout.q <= nxt.q;
    end
  end
endmodule

// ===== sv/m2i_front.sv =====
// Determinant and sign split, registered ahead of the divider chain.
`timescale 1ns / 1ps
module m2i_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vin,
  input  m2i_pkg::entry_t a,
  input  m2i_pkg::entry_t b,
  input  m2i_pkg::entry_t c,
  input  m2i_pkg::entry_t d,
  output m2i_pkg::stage_t dout
);
  import m2i_pkg::*;
  logic signed [2*InWidth-1:0] ad, bc;
  logic signed [DetWidth-1:0] det;
  logic signed [InWidth:0] n [4];
  stage_t nxt;

  // Register the products before the subtract.
  logic vp;
  entry_t pa, pb, pc, pd;
  always_ff @(posedge clk) begin
    if (rst) vp <= 1'b0;
    else if (en) vp <= vin;
    if (en) begin
      ad <= a * d;  bc <= b * c;
      pa <= a; pb <= b; pc <= c; pd <= d;
    end
  end

  always_comb begin
    det = DetWidth'(ad) - DetWidth'(bc);
    n[0] = {pd[InWidth-1], pd};
    n[1] = -{pb[InWidth-1], pb};
    n[2] = -{pc[InWidth-1], pc};
    n[3] = {pa[InWidth-1], pa};
    nxt = '0;
    nxt.valid = vp;
    nxt.det = det;
    nxt.singular = (det == '0);
    nxt.dneg = det[DetWidth-1];
    nxt.dmag = DmagWidth'(det[DetWidth-1] ? -det : det);
    for (int k = 0; k < 4; k++) begin
      nxt.nneg[k] = n[k][InWidth];
      nxt.num[k] = MagWidth'(n[k][InWidth] ? -n[k] : n[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dout.valid <= 1'b0;
    else if (en) dout.valid <= nxt.valid;
    if (en) begin
      dout.det <= nxt.det;        dout.singular <= nxt.singular;
      dout.dmag <= nxt.dmag;      dout.dneg <= nxt.dneg;
      dout.nneg <= nxt.nneg;      dout.num <= nxt.num;
      dout.rem <= nxt.rem;        dout.q <= nxt.q;
    end
  end
endmodule

// ===== sv/matrix_2x2_inverse_core.sv =====
// Top level: 2x2 matrix inverse by adjugate over a chain of division cells.
// Accepts one matrix per cycle while the chain is not stalled. It has two front stages
// (products, then determinant and signs), one restoring-division cell per
// quotient bit (40 cells, all four entries in parallel), and an output stage
// that signs and saturates. The whole chain advances when the output
// register is empty or being taken, so a stall holds every stage.
`timescale 1ns / 1ps
module matrix_2x2_inverse_core (
  input logic clk,
  input logic rst,
  m2i_in_if.sink   in_ch,
  m2i_out_if.source out_ch
);
  import m2i_pkg::*;
  stage_t chain [NumBits+1];
  logic en;
  logic [3:0] clip;
  logic [31:0] res [4];
  logic [QWidth-1:0] qv;
  stage_t last;

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  m2i_front u_front (
    .clk(clk), .rst(rst), .en(en), .vin(in_ch.valid),
    .a(in_ch.entry_a), .b(in_ch.entry_b), .c(in_ch.entry_c), .d(in_ch.entry_d),
    .dout(chain[0])
  );

  for (genvar g = 0; g < NumBits; g++) begin : g_cell
    m2i_div_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .step(CntWidth'(g)),
      .din(chain[g]), .dout(chain[g+1])
    );
  end

  assign last = chain[NumBits];

  // Apply sign and saturate each quotient.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qv = last.q[k];
      if (last.nneg[k] != last.dneg) begin
        clip[k] = (qv > QWidth'(64'h8000_0000));
        res[k] = clip[k] ? 32'h8000_0000 : 32'(-qv);
      end else begin
        clip[k] = (qv > QWidth'(64'h7FFF_FFFF));
        res[k] = clip[k] ? 32'h7FFF_FFFF : qv[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (en) out_ch.valid <= last.valid;
    if (en) begin
      out_ch.det_value <= last.det;
      out_ch.singular <= last.singular;
      out_ch.clipped <= !last.singular && (|clip);
      out_ch.inv_a <= last.singular ? '0 : res[0];
      out_ch.inv_b <= last.singular ? '0 : res[1];
      out_ch.inv_c <= last.singular ? '0 : res[2];
      out_ch.inv_d <= last.singular ? '0 : res[3];
    end
  end
endmodule

// ===== sv/m2i_checker.sv =====
// Port-level checks for the inverse core, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module m2i_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic singular,
  input logic clipped,
  input logic signed [31:0] inv_a,
  input logic signed [32:0] det_value
);
  `CHK_IMPL(a_stall_holds, clk, rst, out_valid && !out_ready, ##1 out_valid)
  `CHK_IMPL(a_ready_free, clk, rst, !out_valid, in_ready)
  `CHK_IMPL(a_sing_zero, clk, rst, out_valid && singular, inv_a == 0 && !clipped && det_value == 0)
  `CHK_IMPL(a_det_sing, clk, rst, out_valid && det_value == 0, singular)
endmodule

bind matrix_2x2_inverse_core m2i_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .singular(out_ch.singular), .clipped(out_ch.clipped),
  .inv_a(out_ch.inv_a), .det_value(out_ch.det_value)
);

// ===== bench/tb.sv =====
// Testbench for the 2x2 fixed-point matrix inverse core: table, then random matrices.
`timescale 1ns / 1ps
module tb;
  import m2i_pkg::*;

  typedef struct packed {
    logic signed [32:0] det;
    logic signed [31:0] ia, ib, ic, id;
    logic sing, clip;
  } inverse_t;

  typedef struct {
    entry_t a, b, c, d;
    logic known;
    inverse_t res;
  } row_t;

  localparam int Latency = 43;
  localparam int CycleLimit = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  m2i_in_if in_ch();
  m2i_out_if out_ch();

  matrix_2x2_inverse_core i_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  inverse_t pending_inverses[$];
  int mismatches = 0;
  int cycles = 0;
  bit hold_sink = 1'b0;
  bit send_done = 1'b0;

  // Quotient of num * 2^Shift by det, truncated toward zero and saturated.
  function automatic logic signed [31:0] fixed_div(longint num, longint det, ref logic clip);
    longint q;
    longint nm;
    longint dm;
    nm = num < 0 ? -num : num;
    dm = det < 0 ? -det : det;
    q = (nm <<< Shift) / dm;
    if ((num < 0) != (det < 0)) begin
      if (q > 64'sd2147483648) begin
        clip = 1'b1;
        q = 64'sd2147483648;
      end
      q = -q;
    end else if (q > 64'sd2147483647) begin
      clip = 1'b1;
      q = 64'sd2147483647;
    end
    return q[31:0];
  endfunction

  function automatic inverse_t invert(entry_t a, entry_t b, entry_t c, entry_t d);
    inverse_t r;
    longint det;
    logic clip;
    det = longint'(a) * longint'(d) - longint'(b) * longint'(c);
    clip = 1'b0;
    r = '{default: '0};
    r.det = det[32:0];
    if (det == 0) begin
      r.sing = 1'b1;
      return r;
    end
    r.ia = fixed_div(longint'(d), det, clip);
    r.ib = fixed_div(-longint'(b), det, clip);
    r.ic = fixed_div(-longint'(c), det, clip);
    r.id = fixed_div(longint'(a), det, clip);
    r.clip = clip;
    return r;
  endfunction

  function automatic entry_t rand_entry();
    case ($urandom_range(0, 5))
      0: return entry_t'($urandom_range(0, 7)) - 16'sd3;
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return entry_t'($urandom_range(0, 1023)) - 16'sd512;
      default: return entry_t'($urandom());
    endcase
  endfunction

  task automatic send(row_t r);
    inverse_t e;
    e = invert(r.a, r.b, r.c, r.d);
    if (r.known && e != r.res) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row %0d %0d %0d %0d: exp %0d %0d %0d %0d %0d %b %b got %0d %0d %0d %0d %0d %b %b",
                 r.a, r.b, r.c, r.d, r.res.det, r.res.ia, r.res.ib, r.res.ic, r.res.id,
                 r.res.sing, r.res.clip, e.det, e.ia, e.ib, e.ic, e.id, e.sing, e.clip);
    end
    // drop valid only for a gap, so back-to-back transfers keep it high
    if ($urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? 30 : 2) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.entry_a <= r.a;
    in_ch.entry_b <= r.b;
    in_ch.entry_c <= r.c;
    in_ch.entry_d <= r.d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_inverses.push_back(e);
    @(negedge clk);
  endtask

  initial begin
    row_t rows[$];
    row_t r;
    in_ch.valid = 1'b0;
    in_ch.entry_a = '0;
    in_ch.entry_b = '0;
    in_ch.entry_c = '0;
    in_ch.entry_d = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // identity, singular all zero, singular rank one, tiny det, extremes
    rows.push_back('{16'sh0100, 0, 0, 16'sh0100, 1,
                     '{33'sh10000, 32'sh10000, 0, 0, 32'sh10000, 0, 0}});
    rows.push_back('{0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 1, 0}});
    rows.push_back('{16'sh0100, 16'sh0200, 16'sh0200, 16'sh0400, 1,
                     '{0, 0, 0, 0, 0, 1, 0}});
    rows.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1,
                     '{0, 0, 0, 0, 0, 1, 0}});
    rows.push_back('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 0, '{default: 0}});
    rows.push_back('{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 0, '{default: 0}});
    rows.push_back('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 0, '{default: 0}});
    rows.push_back('{1, 0, 0, 1, 0, '{default: 0}});
    rows.push_back('{1, 0, 0, -1, 0, '{default: 0}});
    rows.push_back('{16'sh7fff, 0, 0, 1, 0, '{default: 0}});
    rows.push_back('{16'sh8000, 0, 0, 1, 0, '{default: 0}});
    rows.push_back('{16'shffff, 16'shffff, 16'sh7fff, 16'sh8000, 0, '{default: 0}});
    rows.push_back('{-16'sh0100, 16'sh0300, 16'sh0100, 16'sh0200, 0, '{default: 0}});
    rows.push_back('{16'sh5555, 16'shaaaa, 16'sh1234, 16'shedcb, 0, '{default: 0}});
    foreach (rows[i]) send(rows[i]);
    for (int n = 0; n < 1900; n++) begin
      r.a = rand_entry();
      r.b = rand_entry();
      r.c = rand_entry();
      r.d = $urandom_range(0, 15) == 0 && r.a != 0 ? entry_t'(0) : rand_entry();
      // some singular matrices: second row copies the first
      if ($urandom_range(0, 19) == 0) begin
        r.c = r.a;
        r.d = r.b;
      end
      r.known = 1'b0;
      if (n == 600) hold_sink = 1'b1;
      send(r);
    end
    in_ch.valid <= 1'b0;
    send_done = 1'b1;
  end

  // Result-side ready: a long hold-off while the sender keeps offering items, and random stalls.
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_sink = 1'b0;
      end
      if ($urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
          @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    inverse_t e;
    cycles <= cycles + 1;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_inverses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result det=%0d", out_ch.det_value);
      end else begin
        e = pending_inverses.pop_front();
        if (out_ch.det_value !== e.det || out_ch.inv_a !== e.ia || out_ch.inv_b !== e.ib ||
            out_ch.inv_c !== e.ic || out_ch.inv_d !== e.id || out_ch.singular !== e.sing ||
            out_ch.clipped !== e.clip) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d %0d %0d %0d %0d %b %b got %0d %0d %0d %0d %0d %b %b",
                     e.det, e.ia, e.ib, e.ic, e.id, e.sing, e.clip,
                     out_ch.det_value, out_ch.inv_a, out_ch.inv_b, out_ch.inv_c,
                     out_ch.inv_d, out_ch.singular, out_ch.clipped);
        end
      end
    end
  end

  initial begin
    wait (send_done && pending_inverses.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("tb: failure");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/m2i_pkg.sv
sv/m2i_if.sv
sv/m2i_div_cell.sv
sv/m2i_front.sv
sv/matrix_2x2_inverse_core.sv
sv/m2i_checker.sv
bench/tb.sv
